[hw/rtl/dgss_pkg.sv]
// Shared types and constants for the depth-gated skin segmenter.
package dgss_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DEPTH_FAR  = 3'd0,
    REG_DEPTH_NEAR = 3'd1,
    REG_CR_LOW     = 3'd2,
    REG_CR_HIGH    = 3'd3,
    REG_CB_LOW     = 3'd4,
    REG_CB_HIGH    = 3'd5
  } cfg_reg_t;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  // Reset values of the configuration registers.
  localparam logic [15:0] DEPTH_FAR_RST  = 16'd1000;
  localparam logic [15:0] DEPTH_NEAR_RST = 16'd15;
  localparam logic [7:0]  CR_LOW_RST     = 8'd133;
  localparam logic [7:0]  CR_HIGH_RST    = 8'd173;
  localparam logic [7:0]  CB_LOW_RST     = 8'd77;
  localparam logic [7:0]  CB_HIGH_RST    = 8'd127;

  // BT.601 luma weights, Q14.
  localparam logic [12:0] LUMA_R_GAIN = 13'd4899;
  localparam logic [13:0] LUMA_G_GAIN = 14'd9617;
  localparam logic [10:0] LUMA_B_GAIN = 11'd1868;
  localparam logic [21:0] LUMA_ROUND  = 22'd8192;

  // Chroma gains, Q14, and the offset of 128 plus rounding.
  localparam logic signed [23:0] CR_GAIN     = 24'sd11682;
  localparam logic signed [23:0] CB_GAIN     = 24'sd9241;
  localparam logic signed [23:0] CHROMA_BIAS = 24'sd2105344;

  // Gray scaling: (depth - 10) / 5 by reciprocal, exact for 16-bit operands.
  localparam logic [15:0] GRAY_OFFSET = 16'd10;
  localparam logic [15:0] RECIP_5     = 16'd52429;
  localparam int          RecipShift  = 18;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] depth;
  } pixel_t;

  typedef struct packed {
    logic [15:0] depth_far;
    logic [15:0] depth_near;
    logic [7:0]  cr_low;
    logic [7:0]  cr_high;
    logic [7:0]  cb_low;
    logic [7:0]  cb_high;
  } cfg_t;

  // Beat from the front end: gated color and luma partial products.
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  blue;
    logic [20:0] prod_r;
    logic [21:0] prod_g;
    logic [18:0] prod_b;
    logic [7:0]  gray;
  } luma_t;

  // Beat from the chroma unit: biased Q14 chroma sums.
  typedef struct packed {
    logic signed [23:0] sum_cr;
    logic signed [23:0] sum_cb;
    logic [7:0]         gray;
  } chroma_t;

endpackage

[hw/rtl/dgss_if.sv]
// Stream interfaces for the pixel input and the result output.
interface dgss_pixel_if;
  logic        valid;
  logic        ready;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [15:0] depth;

  modport source (output valid, blue, green, red, depth, input ready);
  modport sink (input valid, blue, green, red, depth, output ready);
endinterface

interface dgss_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray;
  logic       skin_mask;

  modport source (output valid, gray, skin_mask, input ready);
  modport sink (input valid, gray, skin_mask, output ready);
endinterface

[hw/rtl/dgss_front.sv]
// Front end: depth gate, gray scaling and luma partial products (two stages).
module dgss_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dgss_pkg::pixel_t in_pix,
  input  dgss_pkg::cfg_t   cfg,
  output logic            out_valid,
  input  logic            out_ready,
  output dgss_pkg::luma_t  out_data
);
  import dgss_pkg::*;

  logic        s1_valid;
  logic        s1_ready;
  logic [7:0]  s1_red;
  logic [7:0]  s1_green;
  logic [7:0]  s1_blue;
  logic        s1_neg;
  logic [7:0]  s1_neg_gray;
  logic [31:0] s1_quot_prod;

  logic        s2_valid;
  logic        s2_ready;
  luma_t       s2_data;

  logic        in_window;
  logic [15:0] depth_sub;
  logic [7:0]  neg_gray;

  // Stall chain: a stage takes a beat when it is empty or its successor moves.
  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Depth gate and the small-depth cases of the truncating division.
  always_comb begin
    in_window = (in_pix.depth > cfg.depth_near) && (in_pix.depth < cfg.depth_far);
    depth_sub = in_pix.depth - GRAY_OFFSET;
    if (in_pix.depth == 16'd0) begin
      neg_gray = 8'd254;
    end else if (in_pix.depth <= 16'd5) begin
      neg_gray = 8'd255;
    end else begin
      neg_gray = 8'd0;
    end
  end

  // Stage 1: gated color and reciprocal product for the gray value.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_red       <= in_window ? in_pix.red : 8'd0;
      s1_green     <= in_window ? in_pix.green : 8'd0;
      s1_blue      <= in_window ? in_pix.blue : 8'd0;
      s1_neg       <= in_pix.depth < GRAY_OFFSET;
      s1_neg_gray  <= neg_gray;
      s1_quot_prod <= 32'(depth_sub) * 32'(RECIP_5);
    end
  end

  // Stage 2: luma products and the final gray byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2_data.red    <= s1_red;
      s2_data.blue   <= s1_blue;
      s2_data.prod_r <= 21'(s1_red * LUMA_R_GAIN);
      s2_data.prod_g <= 22'(s1_green * LUMA_G_GAIN);
      s2_data.prod_b <= 19'(s1_blue * LUMA_B_GAIN);
      s2_data.gray   <= s1_neg ? s1_neg_gray : s1_quot_prod[RecipShift +: 8];
    end
  end

  assign out_valid = s2_valid;
  assign out_data  = s2_data;

endmodule

[hw/rtl/dgss_chroma.sv]
// Chroma unit: luma sum, color differences and scaled chroma (two stages).
module dgss_chroma (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dgss_pkg::luma_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dgss_pkg::chroma_t  out_data
);
  import dgss_pkg::*;

  logic              s3_valid;
  logic              s3_ready;
  logic signed [8:0] s3_diff_r;
  logic signed [8:0] s3_diff_b;
  logic [7:0]        s3_gray;

  logic              s4_valid;
  logic              s4_ready;
  chroma_t           s4_data;

  logic [21:0]       luma_sum;
  logic [7:0]        luma;

  assign s4_ready = !s4_valid || out_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign in_ready = s3_ready;

  // Luma is the rounded Q14 sum; the weights add to one, so it fits a byte.
  always_comb begin
    luma_sum = 22'(in_data.prod_r) + in_data.prod_g + 22'(in_data.prod_b) + LUMA_ROUND;
    luma     = luma_sum[21:14];
  end

  // Stage 3: signed color differences.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= in_valid;
    end
    if (s3_ready && in_valid) begin
      s3_diff_r <= $signed({1'b0, in_data.red}) - $signed({1'b0, luma});
      s3_diff_b <= $signed({1'b0, in_data.blue}) - $signed({1'b0, luma});
      s3_gray   <= in_data.gray;
    end
  end

  // Stage 4: scaled and biased chroma sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
    if (s4_ready && s3_valid) begin
      s4_data.sum_cr <= 24'(s3_diff_r) * CR_GAIN + CHROMA_BIAS;
      s4_data.sum_cb <= 24'(s3_diff_b) * CB_GAIN + CHROMA_BIAS;
      s4_data.gray   <= s3_gray;
    end
  end

  assign out_valid = s4_valid;
  assign out_data  = s4_data;

endmodule

[hw/rtl/dgss_classify.sv]
// Classifier: chroma saturation, window test and the registered result beat.
module dgss_classify (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dgss_pkg::chroma_t  in_data,
  input  dgss_pkg::cfg_t     cfg,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_gray,
  output logic              out_skin
);
  import dgss_pkg::*;

  logic              s5_valid;
  logic              s5_ready;
  logic [7:0]        s5_gray;
  logic              s5_skin;

  logic signed [9:0] cr_wide;
  logic signed [9:0] cb_wide;
  logic [7:0]        cr;
  logic [7:0]        cb;
  logic              skin;

  assign s5_ready = !s5_valid || out_ready;
  assign in_ready = s5_ready;

  // Arithmetic shift down by 14, then clamp to the 0..255 range.
  always_comb begin
    cr_wide = in_data.sum_cr[23:14];
    cb_wide = in_data.sum_cb[23:14];
    if (cr_wide[9]) begin
      cr = 8'd0;
    end else if (cr_wide[8]) begin
      cr = 8'd255;
    end else begin
      cr = cr_wide[7:0];
    end
    if (cb_wide[9]) begin
      cb = 8'd0;
    end else if (cb_wide[8]) begin
      cb = 8'd255;
    end else begin
      cb = cb_wide[7:0];
    end
    skin = (cr > cfg.cr_low) && (cr < cfg.cr_high) &&
           (cb > cfg.cb_low) && (cb < cfg.cb_high);
  end

  // Stage 5: output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (s5_ready) begin
      s5_valid <= in_valid;
    end
    if (s5_ready && in_valid) begin
      s5_gray <= skin ? in_data.gray : 8'd0;
      s5_skin <= skin;
    end
  end

  assign out_valid = s5_valid;
  assign out_gray  = s5_gray;
  assign out_skin  = s5_skin;

endmodule

[hw/rtl/depth_gated_skin_segmenter_core.sv]
// Top level of the depth-gated skin segmenter: config registers and the pipeline.
// Throughput: one pixel per cycle while the output is not stalled; five register
// stages, each stalling on its own, carry a pixel from the input to the result.
// A waiting result stalls new pixels once the stages ahead of it are full.
// Reset (synchronous, active high) empties all stages and loads the default windows.
module depth_gated_skin_segmenter_core (
  input  logic                                  clk,
  input  logic                                  rst,
  dgss_pixel_if.sink                            pixel_in,
  dgss_result_if.source                         result_out,
  input  logic                                  cfg_write,
  input  logic [dgss_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [dgss_pkg::CfgDataWidth-1:0]     cfg_data
);
  import dgss_pkg::*;

  cfg_t    cfg;
  pixel_t  in_pix;

  logic    front_valid;
  logic    front_ready;
  luma_t   front_data;
  logic    chroma_valid;
  logic    chroma_ready;
  chroma_t chroma_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_far  <= DEPTH_FAR_RST;
      cfg.depth_near <= DEPTH_NEAR_RST;
      cfg.cr_low     <= CR_LOW_RST;
      cfg.cr_high    <= CR_HIGH_RST;
      cfg.cb_low     <= CB_LOW_RST;
      cfg.cb_high    <= CB_HIGH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEPTH_FAR:  cfg.depth_far  <= cfg_data;
        REG_DEPTH_NEAR: cfg.depth_near <= cfg_data;
        REG_CR_LOW:     cfg.cr_low     <= cfg_data[7:0];
        REG_CR_HIGH:    cfg.cr_high    <= cfg_data[7:0];
        REG_CB_LOW:     cfg.cb_low     <= cfg_data[7:0];
        REG_CB_HIGH:    cfg.cb_high    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_pix.blue  = pixel_in.blue;
    in_pix.green = pixel_in.green;
    in_pix.red   = pixel_in.red;
    in_pix.depth = pixel_in.depth;
  end

  // Depth gate, gray scaling and luma products.
  dgss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_in.valid),
    .in_ready  (pixel_in.ready),
    .in_pix    (in_pix),
    .cfg       (cfg),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  // Luma, color differences and chroma.
  dgss_chroma u_chroma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (chroma_valid),
    .out_ready (chroma_ready),
    .out_data  (chroma_data)
  );

  // Window test and output register.
  dgss_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chroma_valid),
    .in_ready  (chroma_ready),
    .in_data   (chroma_data),
    .cfg       (cfg),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_gray  (result_out.gray),
    .out_skin  (result_out.skin_mask)
  );

endmodule

[hw/rtl/dgss_checker.sv]
// Port-level checker for the segmenter core and its bind statement.
module dgss_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_gray,
  input logic       out_skin
);
  logic [2:0] occupancy;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // Count of pixels accepted whose result has not been taken yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= 3'd0;
    end else if (in_beat && !out_beat) begin
      occupancy <= occupancy + 3'd1;
    end else if (out_beat && !in_beat) begin
      occupancy <= occupancy - 3'd1;
    end
  end

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_gray) && $stable(out_skin))
    else $error("result changed while stalled");

  // A non-skin result carries a zero gray value.
  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_skin |-> out_gray == 8'd0)
    else $error("gray nonzero on non-skin result");

  // With the output stage empty, the whole pipeline can take a pixel.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // No more pixels in flight than the five stages hold.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    occupancy <= 3'd5)
    else $error("more pixels in flight than stages");

  // Nothing is delivered that was not accepted.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    occupancy == 3'd0 |-> !out_valid)
    else $error("result without an accepted pixel");

endmodule

bind depth_gated_skin_segmenter_core dgss_checker u_dgss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel_in.valid),
  .in_ready  (pixel_in.ready),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .out_gray  (result_out.gray),
  .out_skin  (result_out.skin_mask)
);

[tb/depth_gated_skin_segmenter_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the depth-gated skin segmenter core.
module depth_gated_skin_segmenter_core_tb;
  import dgss_pkg::*;

  // BT.601 weights and offsets used by the expected-segment calculation.
  localparam int LumaRed      = 4899;
  localparam int LumaGreen    = 9617;
  localparam int LumaBlue     = 1868;
  localparam int LumaRound    = 8192;
  localparam int CrWeight     = 11682;
  localparam int CbWeight     = 9241;
  localparam int ChromaOffset = 2105344;
  localparam int GrayBias     = 10;
  localparam int GrayDivisor  = 5;

  localparam int DrainCycles    = 8;
  localparam int PhaseCount     = 8;
  localparam int PixelsPerPhase = 175;

  // Indexes that map to no register; writes to them must change nothing.
  localparam logic [CfgIndexWidth-1:0] UnusedIdxLo = 3'd6;
  localparam logic [CfgIndexWidth-1:0] UnusedIdxHi = 3'd7;

  // A color that lands inside the default chroma windows (Cr 155, Cb 104).
  localparam logic [7:0] SkinBlue  = 8'd120;
  localparam logic [7:0] SkinGreen = 8'd150;
  localparam logic [7:0] SkinRed   = 8'd200;

  typedef struct packed {
    logic [7:0] gray;
    logic       skin_mask;
  } segment_t;

  typedef enum logic { ROW_PIXEL, ROW_WRITE } row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CfgIndexWidth-1:0] idx;
    logic [CfgDataWidth-1:0]  data;
    pixel_t                   px;
    bit                       typed;
    segment_t                 want;
  } plan_row_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;

  dgss_pixel_if  pix ();
  dgss_result_if res ();

  depth_gated_skin_segmenter_core dut (
    .clk        (clk),
    .rst        (rst),
    .pixel_in   (pix),
    .result_out (res),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cfg_t      win;
  segment_t  pending_segments[$];
  plan_row_t plan[$];
  segment_t  head;
  bit        stall_en;
  int        errors;
  int        pixels_sent;
  int        results_seen;
  int        skin_seen;
  int        settings_used;

  // Offset chroma in Q14 with floor shift, clamped to a byte.
  function automatic int chroma_level(input int diff, input int weight);
    int level;
    level = (diff * weight + ChromaOffset) >>> 14;
    if (level < 0) level = 0;
    if (level > 255) level = 255;
    return level;
  endfunction

  // Expected gray and mask for one pixel under the current register shadow.
  function automatic segment_t segment_pixel(input pixel_t px);
    int       r, g, b, luma, cr, cb, quo;
    bit       fg;
    segment_t seg;
    fg = (px.depth > win.depth_near) && (px.depth < win.depth_far);
    r = fg ? int'(px.red) : 0;
    g = fg ? int'(px.green) : 0;
    b = fg ? int'(px.blue) : 0;
    luma = (LumaRed * r + LumaGreen * g + LumaBlue * b + LumaRound) >>> 14;
    cr = chroma_level(r - luma, CrWeight);
    cb = chroma_level(b - luma, CbWeight);
    seg = '0;
    if (cr > int'(win.cr_low) && cr < int'(win.cr_high) &&
        cb > int'(win.cb_low) && cb < int'(win.cb_high)) begin
      // Division truncates toward zero, so shallow depths give a negative quotient.
      quo = (int'(px.depth) - GrayBias) / GrayDivisor;
      seg.gray = quo[7:0];
      seg.skin_mask = 1'b1;
    end
    return seg;
  endfunction

  function automatic plan_row_t pixel_row(input logic [7:0] b, input logic [7:0] g,
                                          input logic [7:0] r, input logic [15:0] d,
                                          input bit typed, input logic [7:0] gray,
                                          input logic mask);
    plan_row_t row;
    row.kind = ROW_PIXEL;
    row.idx = '0;
    row.data = '0;
    row.px.blue = b;
    row.px.green = g;
    row.px.red = r;
    row.px.depth = d;
    row.typed = typed;
    row.want.gray = gray;
    row.want.skin_mask = mask;
    return row;
  endfunction

  function automatic plan_row_t write_row(input logic [CfgIndexWidth-1:0] idx,
                                          input logic [CfgDataWidth-1:0] data);
    plan_row_t row;
    row = pixel_row(8'd0, 8'd0, 8'd0, 16'd0, 1'b0, 8'd0, 1'b0);
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  // Random pixel: mostly skin-like colors at depths inside the window.
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     lo, hi, r, pick;
    lo = int'(win.depth_near);
    hi = int'(win.depth_far);
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      r = $urandom_range(90, 255);
      px.red = 8'(r);
      px.green = 8'($urandom_range(r * 45 / 100, r * 85 / 100));
      px.blue = 8'($urandom_range(r * 30 / 100, r * 75 / 100));
    end else if (pick < 9) begin
      px.red = 8'($urandom);
      px.green = 8'($urandom);
      px.blue = 8'($urandom);
    end else begin
      px.red = 8'($urandom);
      px.green = px.red;
      px.blue = px.red;
    end
    pick = $urandom_range(0, 9);
    if (pick < 6 && hi - lo >= 2) px.depth = 16'($urandom_range(lo + 1, hi - 1));
    else if (pick == 6) px.depth = 16'(lo + int'($urandom_range(0, 1)));
    else if (pick == 7) px.depth = 16'(hi - int'($urandom_range(0, 1)));
    else if (pick == 8) px.depth = 16'($urandom_range(0, 12));
    else px.depth = 16'($urandom);
    return px;
  endfunction

  // One register write; the shadow keeps only the bits the register holds.
  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_DEPTH_FAR:  win.depth_far = data;
      REG_DEPTH_NEAR: win.depth_near = data;
      REG_CR_LOW:     win.cr_low = data[7:0];
      REG_CR_HIGH:    win.cr_high = data[7:0];
      REG_CB_LOW:     win.cb_low = data[7:0];
      REG_CB_HIGH:    win.cb_high = data[7:0];
      default: begin
      end
    endcase
  endtask

  // Writes all six registers; byte registers get junk in their upper bits.
  task automatic program_window(input logic [15:0] far_lim, input logic [15:0] near_lim,
                                input logic [7:0] crl, input logic [7:0] crh,
                                input logic [7:0] cbl, input logic [7:0] cbh);
    write_reg(REG_DEPTH_FAR, far_lim);
    write_reg(REG_DEPTH_NEAR, near_lim);
    write_reg(REG_CR_LOW, {8'($urandom), crl});
    write_reg(REG_CR_HIGH, {8'($urandom), crh});
    write_reg(REG_CB_LOW, {8'($urandom), cbl});
    write_reg(REG_CB_HIGH, {8'($urandom), cbh});
    settings_used++;
  endtask

  // Drop valid and let the pipeline empty before touching registers.
  task automatic settle();
    @(negedge clk);
    pix.valid = 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Present one pixel beat, with random gaps ahead of it, until it is taken.
  task automatic send_pixel(input pixel_t px, input bit typed, input segment_t want);
    @(negedge clk);
    while (stall_en && $urandom_range(0, 99) < 25) begin
      pix.valid = 1'b0;
      @(negedge clk);
    end
    pix.valid = 1'b1;
    pix.blue = px.blue;
    pix.green = px.green;
    pix.red = px.red;
    pix.depth = px.depth;
    do @(posedge clk); while (pix.ready !== 1'b1);
    pending_segments.push_back(typed ? want : segment_pixel(px));
    pixels_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure, redrawn every cycle.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      res.ready = !(stall_en && $urandom_range(0, 99) < 25);
    end
  end

  // Compare every result beat with the oldest expected segment.
  always @(posedge clk) begin
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      results_seen++;
      if (res.skin_mask === 1'b1) skin_seen++;
      if (pending_segments.size() == 0) begin
        $error("result beat with nothing expected: gray %0d, skin_mask %0b",
               res.gray, res.skin_mask);
        errors++;
      end else begin
        head = pending_segments.pop_front();
        if (res.gray !== head.gray) begin
          $error("gray mismatch: expected %0d, actual %0d", head.gray, res.gray);
          errors++;
        end
        if (res.skin_mask !== head.skin_mask) begin
          $error("skin_mask mismatch: expected %0b, actual %0b",
                 head.skin_mask, res.skin_mask);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int lo;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.blue = '0;
    pix.green = '0;
    pix.red = '0;
    pix.depth = '0;
    stall_en = 1'b1;
    win = '{DEPTH_FAR_RST, DEPTH_NEAR_RST, CR_LOW_RST, CR_HIGH_RST, CB_LOW_RST, CB_HIGH_RST};
    settings_used = 1;

    // Default windows: color extremes and both edges of the depth window.
    plan.push_back(pixel_row(8'd0, 8'd0, 8'd0, 16'd0, 1, 8'd0, 1'b0));
    plan.push_back(pixel_row(8'd255, 8'd255, 8'd255, 16'd65535, 1, 8'd0, 1'b0));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd510, 1, 8'd100, 1'b1));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd16, 1, 8'd1, 1'b1));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd15, 1, 8'd0, 1'b0));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd999, 1, 8'd197, 1'b1));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd1000, 1, 8'd0, 1'b0));
    plan.push_back(pixel_row(8'd0, 8'd0, 8'd255, 16'd500, 0, 8'd0, 1'b0));
    plan.push_back(pixel_row(8'd255, 8'd0, 8'd0, 16'd500, 0, 8'd0, 1'b0));
    plan.push_back(pixel_row(8'd0, 8'd255, 8'd0, 16'd500, 0, 8'd0, 1'b0));
    plan.push_back(pixel_row(8'd255, 8'd255, 8'd255, 16'd500, 0, 8'd0, 1'b0));
    plan.push_back(pixel_row(8'd0, 8'd0, 8'd0, 16'd500, 0, 8'd0, 1'b0));
    // Narrow windows around 128 let gated pixels count as skin; upper data bits
    // must be dropped, and writes to unused indexes must not land anywhere.
    plan.push_back(write_row(REG_CR_LOW, 16'hA57F));
    plan.push_back(write_row(REG_CR_HIGH, 16'h0081));
    plan.push_back(write_row(REG_CB_LOW, 16'h3C7F));
    plan.push_back(write_row(REG_CB_HIGH, 16'h0081));
    plan.push_back(write_row(UnusedIdxLo, 16'hFFFF));
    plan.push_back(write_row(UnusedIdxHi, 16'h0000));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd0, 1, 8'd254, 1'b1));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd5, 1, 8'd255, 1'b1));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd9, 1, 8'd0, 1'b1));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd10, 1, 8'd0, 1'b1));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd65535, 1, 8'd49, 1'b1));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd500, 1, 8'd0, 1'b0));
    // An inverted depth window gates every pixel.
    plan.push_back(write_row(REG_DEPTH_FAR, 16'h0000));
    plan.push_back(write_row(REG_DEPTH_NEAR, 16'hFFFF));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd500, 1, 8'd98, 1'b1));
    // An empty Cr window passes nothing.
    plan.push_back(write_row(REG_CR_HIGH, 16'h0080));
    plan.push_back(pixel_row(SkinBlue, SkinGreen, SkinRed, 16'd500, 1, 8'd0, 1'b0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].px, plan[i].typed, plan[i].want);
      end
    end
    settings_used++;

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      settle();
      stall_en = (ph != 3);
      case (ph)
        0: program_window(DEPTH_FAR_RST, DEPTH_NEAR_RST, CR_LOW_RST, CR_HIGH_RST,
                          CB_LOW_RST, CB_HIGH_RST);
        1: program_window(16'hFFFF, 16'h0000, 8'h00, 8'hFF, 8'h00, 8'hFF);
        2: program_window(16'd4000, 16'd20, 8'd200, 8'd100, 8'd100, 8'd100);
        3: begin
          lo = $urandom_range(0, 2000);
          program_window(16'(lo + int'($urandom_range(2, 6000))), 16'(lo),
                         8'($urandom_range(100, 127)), 8'($urandom_range(129, 180)),
                         8'($urandom_range(60, 127)), 8'($urandom_range(129, 160)));
        end
        PhaseCount - 1: program_window(16'($urandom), 16'($urandom), 8'($urandom),
                                       8'($urandom), 8'($urandom), 8'($urandom));
        default: begin
          lo = $urandom_range(0, 600);
          program_window(16'(lo + int'($urandom_range(0, 4000))), 16'(lo),
                         8'($urandom_range(110, 160)), 8'($urandom_range(150, 210)),
                         8'($urandom_range(60, 110)), 8'($urandom_range(100, 170)));
        end
      endcase
      repeat (PixelsPerPhase) send_pixel(random_pixel(), 1'b0, '0);
    end

    settle();
    $display("Sent %0d pixels under %0d register settings.", pixels_sent, settings_used);
    $display("Checked %0d results, %0d of them marked as skin.", results_seen, skin_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
